### design/ckd_pkg.sv
// Shared types, constants and register map for the charlieplex key scanner.
package ckd_pkg;

  localparam int unsigned MAX_PINS = 8;
  localparam int unsigned MIN_PINS = 2;

  localparam logic [3:0]  PIN_COUNT_RST   = 4'd8;
  localparam logic [15:0] DEBOUNCE_MS_RST = 16'd20;

  localparam int unsigned ADDR_W = 3;

  localparam logic REG_PIN_COUNT   = 1'b0;
  localparam logic REG_DEBOUNCE_MS = 1'b1;

  typedef struct packed {
    logic [3:0]  pin_count;
    logic [15:0] debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic       drive_enable;
    logic [2:0] drive_line;
    logic [6:0] debounced_key;
    logic       scan_done;
  } res_t;

endpackage

### design/ckd_cfg_regs.sv
// APB configuration registers for the key scanner.
module ckd_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ckd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ckd_pkg::cfg_t              cfg_o
);

  logic [3:0]  pin_count_q, pin_count_d;
  logic [15:0] debounce_q, debounce_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    pin_count_d = pin_count_q;
    debounce_d  = debounce_q;
    if (wr_en) begin
      unique case (paddr[2])
        ckd_pkg::REG_PIN_COUNT:   pin_count_d = pwdata[3:0];
        ckd_pkg::REG_DEBOUNCE_MS: debounce_d  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ckd_pkg::REG_PIN_COUNT:   prdata = {28'd0, pin_count_q};
      ckd_pkg::REG_DEBOUNCE_MS: prdata = {16'd0, debounce_q};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_count_q <= ckd_pkg::PIN_COUNT_RST;
      debounce_q  <= ckd_pkg::DEBOUNCE_MS_RST;
    end else begin
      pin_count_q <= pin_count_d;
      debounce_q  <= debounce_d;
    end
  end

  assign cfg_o.pin_count   = pin_count_q;
  assign cfg_o.debounce_ms = debounce_q;

endmodule

### design/ckd_line_decode.sv
// Decode of one sensed line pattern into a raw key index.
module ckd_line_decode (
  input  logic [7:0] raw_i,
  input  logic [2:0] line_i,
  input  logic [3:0] pins_i,
  output logic [6:0] key_o
);

  logic [7:0] pat;
  logic [7:0] last_pat;
  logic [3:0] col;
  logic [6:0] prod;

  always_comb begin
    pat = raw_i;
    if ($onehot(raw_i)) begin
      pat = raw_i | (8'd1 << line_i);
    end
    last_pat = 8'd1 | (8'd1 << (pins_i - 4'd1));
    col      = 4'd0;
    if (pat == last_pat) begin
      col = pins_i;
    end else begin
      for (int j = 7; j >= 1; j--) begin
        if ((4'(j) < pins_i) && (pat == (8'd3 << (j - 1)))) begin
          col = 4'(j);
        end
      end
    end
    prod = 7'(line_i) * 7'(pins_i);
    key_o = (col == 4'd0) ? 7'd0 : 7'(7'(col) + prod);
  end

endmodule

### design/ckd_scan_core.sv
// Scan state, debounce wait and key acceptance, advanced once per word.
module ckd_scan_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          ms_tick_i,
  input  logic [7:0]    sense_low_i,
  input  ckd_pkg::cfg_t cfg_i,
  output ckd_pkg::res_t res_o
);

  logic        scan_q, scan_d;
  logic [2:0]  line_q, line_d;
  logic [15:0] wait_q, wait_d;
  logic [6:0]  prev_q, prev_d;
  logic [6:0]  acc_q, acc_d;

  logic [3:0] pins;
  logic [8:0] mask9;
  logic [7:0] raw;
  logic [6:0] dec_key;
  logic [3:0] line_inc;
  logic [15:0] wait_dec;
  logic       finish;
  logic [6:0] fin_key;

  always_comb begin
    pins = cfg_i.pin_count;
    if (pins < 4'(ckd_pkg::MIN_PINS)) pins = 4'(ckd_pkg::MIN_PINS);
    if (pins > 4'(ckd_pkg::MAX_PINS)) pins = 4'(ckd_pkg::MAX_PINS);
  end

  assign mask9    = (9'd1 << pins) - 9'd1;
  assign raw      = sense_low_i & mask9[7:0] & ~(8'd1 << line_q);
  assign line_inc = {1'b0, line_q} + 4'd1;

  ckd_line_decode u_dec (
    .raw_i  (raw),
    .line_i (line_q),
    .pins_i (pins),
    .key_o  (dec_key)
  );

  always_comb begin
    scan_d   = scan_q;
    line_d   = line_q;
    wait_d   = wait_q;
    prev_d   = prev_q;
    acc_d    = acc_q;
    finish   = 1'b0;
    fin_key  = 7'd0;
    wait_dec = wait_q;
    if (!scan_q) begin
      if (ms_tick_i && (wait_q != 16'd0)) begin
        wait_dec = wait_q - 16'd1;
      end
      wait_d = wait_dec;
      if (wait_dec == 16'd0) begin
        scan_d = 1'b1;
        line_d = 3'd0;
      end
    end else if ({1'b0, line_q} >= pins) begin
      finish = 1'b1;
    end else if (raw != 8'd0) begin
      finish  = 1'b1;
      fin_key = dec_key;
    end else if (line_inc >= pins) begin
      finish = 1'b1;
    end else begin
      line_d = line_inc[2:0];
    end
    if (finish) begin
      acc_d  = (fin_key == prev_q) ? fin_key : 7'd0;
      prev_d = fin_key;
      wait_d = cfg_i.debounce_ms;
      scan_d = 1'b0;
      line_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= 1'b0;
      line_q <= 3'd0;
      wait_q <= 16'd0;
      prev_q <= 7'd0;
      acc_q  <= 7'd0;
    end else if (step_i) begin
      scan_q <= scan_d;
      line_q <= line_d;
      wait_q <= wait_d;
      prev_q <= prev_d;
      acc_q  <= acc_d;
    end
  end

  assign res_o.drive_enable  = scan_d;
  assign res_o.drive_line    = scan_d ? line_d : 3'd0;
  assign res_o.debounced_key = acc_d;
  assign res_o.scan_done     = finish;

endmodule

### design/charlieplex_key_scan_debounce_unit.sv
// Top level of the charlieplexed keypad scanner with two-scan debounce.
// Each input word carries the pins sensed low for the line announced by the
// previous result, plus a millisecond tick; each word gives exactly one
// result word naming the next line to drive, the accepted key (0 for none)
// and whether a scan ended. Words are taken one per clock cycle while the
// output is not stalled: a word is captured in an input register, decoded
// and applied to the scan state in a single pass, and the result is held in
// an output register. The user must make configuration writes through the
// APB port only while no word is in flight; the block does not enforce it.
module charlieplex_key_scan_debounce_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       ms_tick_i,
  input  logic [7:0]                 sense_low_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       drive_enable_o,
  output logic [2:0]                 drive_line_o,
  output logic [6:0]                 debounced_key_o,
  output logic                       scan_done_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ckd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  ckd_pkg::cfg_t cfg;
  ckd_pkg::res_t res;
  ckd_pkg::res_t res_q;

  logic       in_vld_q, in_vld_d;
  logic       tick_q;
  logic [7:0] sense_q;
  logic       out_vld_q, out_vld_d;
  logic       step;
  logic       in_take;

  ckd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  ckd_scan_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .ms_tick_i   (tick_q),
    .sense_low_i (sense_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tick_q  <= ms_tick_i;
      sense_q <= sense_low_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign drive_enable_o  = res_q.drive_enable;
  assign drive_line_o    = res_q.drive_line;
  assign debounced_key_o = res_q.debounced_key;
  assign scan_done_o     = res_q.scan_done;

endmodule

### design/ckd_checker.sv
// Port-level checks for the key scanner, bound to the top level.
module ckd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       drive_enable_o,
  input logic [2:0] drive_line_o,
  input logic [6:0] debounced_key_o,
  input logic       scan_done_o
);

  a_idle_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drive_enable_o |-> drive_line_o == 3'd0)
    else $error("drive line nonzero while not driving");

  a_done_not_driving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scan_done_o |-> !drive_enable_o)
    else $error("scan done while still driving a line");

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> debounced_key_o <= 7'd64)
    else $error("key index out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(debounced_key_o)
      && $stable(drive_line_o))
    else $error("stalled result word changed");

endmodule

bind charlieplex_key_scan_debounce_unit ckd_checker u_ckd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .drive_enable_o  (drive_enable_o),
  .drive_line_o    (drive_line_o),
  .debounced_key_o (debounced_key_o),
  .scan_done_o     (scan_done_o)
);

### bench/testbench.sv
// Self-checking bench for the charlieplexed key scanner: table, deep random scans, APB setup.
module testbench;

  typedef enum logic [1:0] {CFG_NONE, CFG_PINS, CFG_DEBOUNCE} cfg_sel_e;

  typedef struct {
    cfg_sel_e      wr;
    logic [15:0]   wval;
    logic          tick;
    logic [7:0]    sense;
    bit            known;
    ckd_pkg::res_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        ms_tick = 1'b0;
  logic [7:0]  sense_low = 8'h00;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ckd_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 32'h0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        drive_enable_o;
  logic [2:0]  drive_line_o;
  logic [6:0]  debounced_key_o;
  logic        scan_done_o;
  logic [31:0] prdata;
  logic        pready;

  bit            word_known = 1'b0;
  ckd_pkg::res_t word_res = '0;

  // scanner mirror
  logic [3:0]  pins_cfg = ckd_pkg::PIN_COUNT_RST;
  logic [15:0] debounce_cfg = ckd_pkg::DEBOUNCE_MS_RST;
  bit          scan_busy = 1'b0;
  int unsigned scan_line = 0;
  logic [15:0] wait_left = '0;
  logic [6:0]  prev_raw = '0;
  logic [6:0]  held_key = '0;

  ckd_pkg::res_t scan_results_q[$];
  int          mism_count = 0;

  int unsigned target_line = 0;
  int unsigned target_col = 1;

  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int unsigned rx_count = 0;
  int unsigned rx_mode = 0;

  row_t        dir_rows [23];

  charlieplex_key_scan_debounce_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .ms_tick_i      (ms_tick),
    .sense_low_i    (sense_low),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .drive_enable_o (drive_enable_o),
    .drive_line_o   (drive_line_o),
    .debounced_key_o(debounced_key_o),
    .scan_done_o    (scan_done_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #2 clk = ~clk;

  function automatic int unsigned pins_used();
    if (pins_cfg < ckd_pkg::MIN_PINS) return ckd_pkg::MIN_PINS;
    if (pins_cfg > ckd_pkg::MAX_PINS) return ckd_pkg::MAX_PINS;
    return pins_cfg;
  endfunction

  function automatic void close_scan(input logic [6:0] raw_key);
    held_key  = (raw_key == prev_raw) ? raw_key : 7'd0;
    prev_raw  = raw_key;
    wait_left = debounce_cfg;
    scan_busy = 1'b0;
    scan_line = 0;
  endfunction

  function automatic ckd_pkg::res_t scan_step(input logic tick, input logic [7:0] sense);
    int unsigned   n;
    int unsigned   col;
    logic [7:0]    mask;
    logic [7:0]    raw;
    logic          done;
    ckd_pkg::res_t r;
    n = pins_used();
    done = 1'b0;
    if (!scan_busy) begin
      if (tick && wait_left != 0) wait_left--;
      if (wait_left == 0) begin
        scan_busy = 1'b1;
        scan_line = 0;
      end
    end else if (scan_line >= n) begin
      close_scan(7'd0);
      done = 1'b1;
    end else begin
      mask = 8'((9'd1 << n) - 9'd1);
      raw  = sense & mask & ~(8'd1 << scan_line);
      if (raw != 8'd0) begin
        if ($countones(raw) == 1) raw |= 8'd1 << scan_line;
        col = 0;
        if (raw == (8'd1 | (8'd1 << (n - 1)))) begin
          col = n;
        end else begin
          for (int j = 1; j < n; j++) begin
            if (col == 0 && raw == (8'd3 << (j - 1))) col = j;
          end
        end
        close_scan((col == 0) ? 7'd0 : 7'(col + scan_line * n));
        done = 1'b1;
      end else begin
        scan_line++;
        if (scan_line >= n) begin
          close_scan(7'd0);
          done = 1'b1;
        end
      end
    end
    r.drive_enable  = scan_busy;
    r.drive_line    = scan_busy ? 3'(scan_line) : 3'd0;
    r.debounced_key = held_key;
    r.scan_done     = done;
    return r;
  endfunction

  function automatic logic pick_tick();
    if (scan_busy) return 1'($urandom_range(0, 1));
    return $urandom_range(0, 9) < 7;
  endfunction

  // shape scans: blank lines up to a target line, then a key pattern there
  function automatic logic [7:0] pick_sense();
    int unsigned n;
    int unsigned sel;
    logic [7:0]  mask;
    logic [7:0]  junk;
    logic [7:0]  pat;
    n = pins_used();
    if (!scan_busy) return 8'($urandom);
    mask = 8'((9'd1 << n) - 9'd1);
    junk = ($urandom_range(0, 1) != 0) ? (8'($urandom) & ~mask) : 8'h00;
    if (scan_line == 0 && $urandom_range(0, 1) != 0) begin
      target_line = $urandom_range(0, n);
      target_col  = $urandom_range(1, n);
    end
    if (target_line > n) target_line = n;
    if (target_col > n) target_col = n;
    sel = $urandom_range(0, 99);
    if (scan_line < target_line) begin
      if (sel < 90) return junk | (($urandom_range(0, 1) != 0) ? 8'd1 << scan_line : 8'd0);
      return 8'($urandom);
    end
    if (scan_line > target_line) begin
      if (sel < 50) return junk;
      return 8'($urandom);
    end
    if (sel < 70) begin
      pat = (target_col == n) ? (8'd1 | (8'd1 << (n - 1))) : (8'd3 << (target_col - 1));
      if ($urandom_range(0, 1) != 0) pat &= ~(8'd1 << scan_line);
      return pat | junk;
    end
    if (sel < 85) return 8'd1 << $urandom_range(0, 7);
    return 8'($urandom);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic put_word(input logic t, input logic [7:0] s, input bit kn,
                          input ckd_pkg::res_t r);
    in_valid   <= 1'b1;
    ms_tick    <= t;
    sense_low  <= s;
    word_known <= kn;
    word_res   <= r;
    do @(posedge clk); while (in_stall_o);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int unsigned k);
    if (k > 0) begin
      in_valid <= 1'b0;
      repeat (k) @(negedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (scan_results_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] v);
    logic [31:0] keep;
    settle();
    keep    = (idx == ckd_pkg::REG_PIN_COUNT) ? 32'hF : 32'hFFFF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~keep) | ({16'h0, v} & keep);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == ckd_pkg::REG_PIN_COUNT) pins_cfg = v[3:0];
    else debounce_cfg = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_words(input int unsigned count);
    int unsigned left;
    int unsigned burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && left > 0; k++) begin
        put_word(pick_tick(), pick_sense(), 1'b0, '0);
        left--;
      end
      idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4));
    end
  endtask

  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 300;
    end
    if (rx_count % 40 == 0) rx_mode = $urandom_range(0, 3);
    rx_count++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= (rx_count[1:0] != 2'd0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    ckd_pkg::res_t got;
    ckd_pkg::res_t want;
    ckd_pkg::res_t calc;
    if (out_valid_o && !out_stall) begin
      got = '{drive_enable_o, drive_line_o, debounced_key_o, scan_done_o};
      if (scan_results_q.size() == 0) begin
        $error("result word with nothing pending: %p", got);
        mism_count++;
      end else begin
        want = scan_results_q.pop_front();
        if (got.drive_enable !== want.drive_enable) begin
          $error("drive_enable: expected %0d, got %0d", want.drive_enable, got.drive_enable);
          mism_count++;
        end
        if (got.drive_line !== want.drive_line) begin
          $error("drive_line: expected %0d, got %0d", want.drive_line, got.drive_line);
          mism_count++;
        end
        if (got.debounced_key !== want.debounced_key) begin
          $error("debounced_key: expected %0d, got %0d", want.debounced_key,
                 got.debounced_key);
          mism_count++;
        end
        if (got.scan_done !== want.scan_done) begin
          $error("scan_done: expected %0d, got %0d", want.scan_done, got.scan_done);
          mism_count++;
        end
      end
    end
    if (in_valid && !in_stall_o) begin
      calc = scan_step(ms_tick, sense_low);
      scan_results_q.push_back(word_known ? word_res : calc);
    end
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned pin_set [8];
    int unsigned deb_set [8];
    pin_set = '{8, 2, 5, 8, 1, 9, 3, 15};
    deb_set = '{20, 0, 1, 3, 0, 2, 0, 1};
    dir_rows = '{
      '{CFG_NONE,     16'd0,  1'b0, 8'hFF, 1'b1, ckd_pkg::res_t'{1'b1, 3'd0, 7'd0, 1'b0}},
      '{CFG_DEBOUNCE, 16'd0,  1'b0, 8'h02, 1'b1, ckd_pkg::res_t'{1'b0, 3'd0, 7'd0, 1'b1}},
      '{CFG_NONE,     16'd0,  1'b0, 8'h00, 1'b1, ckd_pkg::res_t'{1'b1, 3'd0, 7'd0, 1'b0}},
      '{CFG_NONE,     16'd0,  1'b1, 8'h02, 1'b1, ckd_pkg::res_t'{1'b0, 3'd0, 7'd1, 1'b1}},
      '{CFG_NONE,     16'd0,  1'b0, 8'h00, 1'b1, ckd_pkg::res_t'{1'b1, 3'd0, 7'd1, 1'b0}},
      '{CFG_NONE,     16'd0,  1'b0, 8'hFF, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_NONE,     16'd0,  1'b0, 8'h00, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_NONE,     16'd0,  1'b0, 8'h00, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_NONE,     16'd0,  1'b1, 8'h81, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_NONE,     16'd0,  1'b0, 8'h00, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_NONE,     16'd0,  1'b0, 8'h00, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_NONE,     16'd0,  1'b0, 8'h81, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_PINS,     16'd2,  1'b0, 8'hFC, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_NONE,     16'd0,  1'b0, 8'hFC, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_NONE,     16'd0,  1'b0, 8'h00, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_PINS,     16'd15, 1'b1, 8'h00, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_NONE,     16'd0,  1'b0, 8'h00, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_NONE,     16'd0,  1'b0, 8'h00, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_PINS,     16'd0,  1'b0, 8'hFF, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_PINS,     16'd8,  1'b0, 8'h00, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_NONE,     16'd0,  1'b0, 8'h80, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_NONE,     16'd0,  1'b0, 8'h00, 1'b0, ckd_pkg::res_t'('0)},
      '{CFG_NONE,     16'd0,  1'b0, 8'h00, 1'b0, ckd_pkg::res_t'('0)}
    };

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].wr)
        CFG_PINS:     write_reg(ckd_pkg::REG_PIN_COUNT, dir_rows[i].wval);
        CFG_DEBOUNCE: write_reg(ckd_pkg::REG_DEBOUNCE_MS, dir_rows[i].wval);
        default: ;
      endcase
      put_word(dir_rows[i].tick, dir_rows[i].sense, dir_rows[i].known, dir_rows[i].res);
    end

    // longer wait once: finish the scan, then tick the full count down
    write_reg(ckd_pkg::REG_DEBOUNCE_MS, 16'd24);
    while (scan_busy) put_word(1'b0, 8'h00, 1'b0, '0);
    while (!scan_busy) put_word(1'b1, 8'($urandom), 1'b0, '0);

    for (int p = 0; p < 8; p++) begin
      write_reg(ckd_pkg::REG_PIN_COUNT, 16'(pin_set[p]));
      write_reg(ckd_pkg::REG_DEBOUNCE_MS, 16'(deb_set[p]));
      if (p == 3) hold_req++;
      random_words(50);
    end

    settle();
    repeat (8) @(posedge clk);
    if (mism_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### charlieplex_key_scan_debounce_unit.f
design/ckd_pkg.sv
design/ckd_cfg_regs.sv
design/ckd_line_decode.sv
design/ckd_scan_core.sv
design/charlieplex_key_scan_debounce_unit.sv
design/ckd_checker.sv
bench/testbench.sv
